/* hdl/cor_pkg.sv */
// ---------------------------------------------------------------------------
// cor_pkg
// shared types and constants for the circle octant rasterizer
// ---------------------------------------------------------------------------
package cor_pkg;

    // field widths of the command and pixel items
    localparam int CENTER_W = 10;
    localparam int RADIUS_W = 9;
    localparam int PIX_BITS = 12;

    // defaults for the top level parameters
    localparam int COORD_BITS_DEF  = 10;
    localparam int RADIUS_BITS_DEF = 9;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [RADIUS_W-1:0] radius;
    } cmd_item_t;

    typedef struct packed {
        logic signed [PIX_BITS-1:0] pixel_x;
        logic signed [PIX_BITS-1:0] pixel_y;
        logic                       pixel_valid;
        logic                       last_pixel;
    } pix_item_t;

endpackage

/* hdl/circle_octant_rasterizer.sv */
// ---------------------------------------------------------------------------
// circle_octant_rasterizer
// midpoint circle walk over one octant, mirrored into eight pixels per point
// ---------------------------------------------------------------------------
// a step item that is accepted shows its pixel item in the cycle after
// throughput: one item per cycle; stall on the pixel side holds the output
//   register and stalls the command side only while that register is full
// the midpoint decision lags the octant point by the squares and keep_y registers
//   of cor_decide, and is always ready since a point is held for eight steps
// reset: asynchronous, active low; clears walk state and the output valid
module circle_octant_rasterizer #(
    parameter int COORD_BITS  = cor_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = cor_pkg::RADIUS_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  cor_pkg::cmd_item_t cmd,
    output logic              pix_valid,
    input  logic              pix_stall,
    output cor_pkg::pix_item_t pix
);

    // width for modular pixel arithmetic; low PIX_BITS bits are kept
    localparam int MAX_CR = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
    localparam int SUM_W  = (MAX_CR > cor_pkg::PIX_BITS) ? MAX_CR : cor_pkg::PIX_BITS;
    localparam int NXT_W  = RADIUS_BITS + 2;

    // walk state
    logic [RADIUS_BITS-1:0] oct_x_reg,  oct_x_next;
    logic [RADIUS_BITS-1:0] oct_y_reg,  oct_y_next;
    logic [2:0]             mirror_reg, mirror_next;
    logic [COORD_BITS-1:0]  cx_reg,     cx_next;
    logic [COORD_BITS-1:0]  cy_reg,     cy_next;
    logic [RADIUS_BITS-1:0] rad_reg,    rad_next;
    logic                   busy_reg,   busy_next;

    // output register
    cor_pkg::pix_item_t     pix_reg,       pix_next;
    logic                   pix_valid_reg, pix_valid_next;

    logic                   accept;
    logic                   keep_y;
    logic                   swap;
    logic                   neg_x;
    logic                   neg_y;
    logic [RADIUS_BITS-1:0] mag_x;
    logic [RADIUS_BITS-1:0] mag_y;
    logic [SUM_W-1:0]       sum_x;
    logic [SUM_W-1:0]       sum_y;
    logic signed [NXT_W-1:0] nx;
    logic signed [NXT_W-1:0] ny;
    logic                   walk_done;

    // the command side stalls only when a pixel is waiting and not taken
    assign cmd_stall = pix_valid_reg & pix_stall;
    assign accept    = cmd_valid & ~cmd_stall;

    // decision for the point held in oct_x_reg / oct_y_reg
    cor_decide #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_decide (
        .clk    (clk),
        .rst_n  (rst_n),
        .oct_x  (oct_x_reg),
        .oct_y  (oct_y_reg),
        .radius (rad_reg),
        .keep_y (keep_y)
    );

    // mirror select: bit 2 swaps x and y, bit 0 negates x, bit 1 negates y
    assign swap  = mirror_reg[2];
    assign neg_x = mirror_reg[0];
    assign neg_y = mirror_reg[1];
    assign mag_x = swap ? oct_y_reg : oct_x_reg;
    assign mag_y = swap ? oct_x_reg : oct_y_reg;

    assign sum_x = neg_x ? SUM_W'(cx_reg) - SUM_W'(mag_x) : SUM_W'(cx_reg) + SUM_W'(mag_x);
    assign sum_y = neg_y ? SUM_W'(cy_reg) - SUM_W'(mag_y) : SUM_W'(cy_reg) + SUM_W'(mag_y);

    // next octant point and end of walk
    assign nx = $signed(NXT_W'(oct_x_reg)) + NXT_W'(1);
    assign ny = keep_y ? $signed(NXT_W'(oct_y_reg))
                       : $signed(NXT_W'(oct_y_reg)) - NXT_W'(1);
    assign walk_done = (nx > ny);

    always_comb
    begin
        oct_x_next     = oct_x_reg;
        oct_y_next     = oct_y_reg;
        mirror_next    = mirror_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        rad_next       = rad_reg;
        busy_next      = busy_reg;
        pix_next       = pix_reg;
        pix_valid_next = pix_valid_reg & pix_stall;

        if (accept)
        begin
            if (cmd.opcode == cor_pkg::OP_START)
            begin
                // start: latch centre and radius, arm at (0, r)
                cx_next     = COORD_BITS'(cmd.center_x);
                cy_next     = COORD_BITS'(cmd.center_y);
                rad_next    = RADIUS_BITS'(cmd.radius);
                oct_x_next  = '0;
                oct_y_next  = RADIUS_BITS'(cmd.radius);
                mirror_next = '0;
                busy_next   = 1'b1;
            end
            else
            begin
                pix_valid_next = 1'b1;
                if (!busy_reg)
                begin
                    // step while idle gives an empty pixel
                    pix_next = '0;
                end
                else
                begin
                    pix_next.pixel_x     = $signed(sum_x[cor_pkg::PIX_BITS-1:0]);
                    pix_next.pixel_y     = $signed(sum_y[cor_pkg::PIX_BITS-1:0]);
                    pix_next.pixel_valid = 1'b1;
                    pix_next.last_pixel  = 1'b0;
                    if (mirror_reg == 3'd7)
                    begin
                        mirror_next = '0;
                        if (walk_done)
                        begin
                            pix_next.last_pixel = 1'b1;
                            busy_next           = 1'b0;
                        end
                        else
                        begin
                            oct_x_next = nx[RADIUS_BITS-1:0];
                            oct_y_next = ny[RADIUS_BITS-1:0];
                        end
                    end
                    else
                    begin
                        mirror_next = mirror_reg + 3'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_x_reg     <= '0;
            oct_y_reg     <= '0;
            mirror_reg    <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            rad_reg       <= '0;
            busy_reg      <= 1'b0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            oct_x_reg     <= oct_x_next;
            oct_y_reg     <= oct_y_next;
            mirror_reg    <= mirror_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            rad_reg       <= rad_next;
            busy_reg      <= busy_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
    end

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

    // idle walk sits at the first mirror
    a_idle_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (mirror_reg == 3'd0))
        else $error("mirror index not cleared while idle");

    // the walk never leaves the octant x <= y
    a_octant: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (oct_x_reg <= oct_y_reg))
        else $error("octant point outside x <= y");

    // a flagged last pixel is always a real pixel
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid_reg && pix_reg.last_pixel) |-> pix_reg.pixel_valid)
        else $error("last pixel flagged on an empty item");

    // a start arms the walk at x zero, first mirror
    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.opcode == cor_pkg::OP_START)
        |=> (busy_reg && mirror_reg == 3'd0 && oct_x_reg == '0))
        else $error("start did not arm the walk");

    // the eighth mirror wraps the index
    a_mirror_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.opcode == cor_pkg::OP_STEP && busy_reg && mirror_reg == 3'd7)
        |=> (mirror_reg == 3'd0))
        else $error("mirror index did not wrap after the eighth mirror");

endmodule

/* hdl/cor_decide.sv */
// ---------------------------------------------------------------------------
// cor_decide
// midpoint decision for the current octant point, two register stages
// ---------------------------------------------------------------------------
module cor_decide #(
    parameter int RADIUS_BITS = cor_pkg::RADIUS_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [RADIUS_BITS-1:0] oct_x,
    input  logic [RADIUS_BITS-1:0] oct_y,
    input  logic [RADIUS_BITS-1:0] radius,
    output logic                   keep_y
);

    localparam int SQX_W = 2 * RADIUS_BITS + 2;
    localparam int SQ_W  = 2 * RADIUS_BITS;
    localparam int ERR_W = 2 * RADIUS_BITS + 5;

    logic [RADIUS_BITS:0]   xp1;
    logic [RADIUS_BITS-1:0] ym1;
    logic [SQX_W-1:0]       sq_xp1_reg;
    logic [SQ_W-1:0]        sq_y_reg;
    logic [SQ_W-1:0]        sq_ym1_reg;
    logic [SQ_W-1:0]        sq_r_reg;
    logic signed [ERR_W-1:0] err;
    logic                   keep_y_reg;
    logic                   keep_y_next;

    // |y-1|, which is 1 when y is zero
    assign xp1 = {1'b0, oct_x} + (RADIUS_BITS+1)'(1);
    assign ym1 = (oct_y == '0) ? RADIUS_BITS'(1) : oct_y - RADIUS_BITS'(1);

    // stage 1: squares
    always_ff @(posedge clk)
    begin
        sq_xp1_reg <= SQX_W'(xp1) * SQX_W'(xp1);
        sq_y_reg   <= SQ_W'(oct_y) * SQ_W'(oct_y);
        sq_ym1_reg <= SQ_W'(ym1) * SQ_W'(ym1);
        sq_r_reg   <= SQ_W'(radius) * SQ_W'(radius);
    end

    // stage 2: summed squared error against r squared
    assign err = $signed(ERR_W'({sq_xp1_reg, 1'b0}))
               + $signed(ERR_W'(sq_y_reg))
               + $signed(ERR_W'(sq_ym1_reg))
               - $signed(ERR_W'({sq_r_reg, 1'b0}));
    assign keep_y_next = (err <= 0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_y_reg <= 1'b0;
        end
        else
        begin
            keep_y_reg <= keep_y_next;
        end
    end

    assign keep_y = keep_y_reg;

endmodule

/* dv/circle_octant_rasterizer_tb.sv */
// ---------------------------------------------------------------------------
// circle_octant_rasterizer_tb
// self-checking bench for the midpoint circle rasterizer: command items
// (starts and pixel requests) go in under random bursts and gaps, and every
// pixel item that comes out is checked field by field against an in-bench
// prediction of the octant walk and its eight mirrors
// ---------------------------------------------------------------------------
module circle_octant_rasterizer_tb;

    localparam int HALF_PERIOD  = 2;
    localparam int TIME_LIMIT   = 2_000_000;
    localparam int RANDOM_ITEMS = 1460;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_stall;
    cor_pkg::cmd_item_t cmd       = '0;
    logic               pix_valid;
    logic               pix_stall = 1'b0;
    cor_pkg::pix_item_t pix;

    // predicted walk state, mirrors the block after each accepted item
    int                           walk_x;
    int                           walk_y;
    logic [2:0]                   mirror_sel;
    logic [cor_pkg::CENTER_W-1:0] held_cx;
    logic [cor_pkg::CENTER_W-1:0] held_cy;
    logic [cor_pkg::RADIUS_W-1:0] held_r;
    bit                           walk_busy;

    cor_pkg::pix_item_t expected_pixels[$];
    cor_pkg::pix_item_t want_pixel;

    int error_count = 0;
    int items_sent  = 0;

    // sender idling: bursts of random length, gaps of random length bounded by gap_max
    int burst_left = 0;
    int gap_max    = 0;

    // receiver idling: 0 never stalls, 1 light pattern, 2 heavy pattern
    int rx_style    = 0;
    int hold_cycles = 0;

    circle_octant_rasterizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // prediction of the octant walk
    // ------------------------------------------------------------------

    // updates the walk for one accepted command item and queues the pixel
    // item that a request produces; a start produces nothing
    function automatic void predict_pixel(input cor_pkg::cmd_item_t c);
        cor_pkg::pix_item_t px;
        int        dx;
        int        dy;
        int        sx;
        int        sy;
        longint    x1;
        longint    y0;
        longint    rr;
        longint    err;
        px = '0;
        dx = 0;
        dy = 0;
        if (c.opcode == cor_pkg::OP_START)
        begin
            held_cx    = c.center_x;
            held_cy    = c.center_y;
            held_r     = c.radius;
            walk_x     = 0;
            walk_y     = int'(c.radius);
            mirror_sel = 3'd0;
            walk_busy  = 1'b1;
            return;
        end
        // a request while idle gives an all-zero item
        if (walk_busy)
        begin
            case (mirror_sel)
                3'd0:
                begin
                    dx = walk_x;
                    dy = walk_y;
                end
                3'd1:
                begin
                    dx = -walk_x;
                    dy = walk_y;
                end
                3'd2:
                begin
                    dx = walk_x;
                    dy = -walk_y;
                end
                3'd3:
                begin
                    dx = -walk_x;
                    dy = -walk_y;
                end
                3'd4:
                begin
                    dx = walk_y;
                    dy = walk_x;
                end
                3'd5:
                begin
                    dx = -walk_y;
                    dy = walk_x;
                end
                3'd6:
                begin
                    dx = walk_y;
                    dy = -walk_x;
                end
                default:
                begin
                    dx = -walk_y;
                    dy = -walk_x;
                end
            endcase
            sx = int'(held_cx) + dx;
            sy = int'(held_cy) + dy;
            px.pixel_x     = sx[cor_pkg::PIX_BITS-1:0];
            px.pixel_y     = sy[cor_pkg::PIX_BITS-1:0];
            px.pixel_valid = 1'b1;
            if (mirror_sel == 3'd7)
            begin
                // midpoint decision: sum of squared errors of both candidates
                x1  = longint'(walk_x) + 1;
                y0  = longint'(walk_y);
                rr  = longint'(held_r);
                err = 2 * x1 * x1 + y0 * y0 + (y0 - 1) * (y0 - 1) - 2 * rr * rr;
                if (err > 0)
                    y0 = y0 - 1;
                if (x1 > y0)
                begin
                    px.last_pixel = 1'b1;
                    walk_busy     = 1'b0;
                end
                else
                begin
                    walk_x = int'(x1);
                    walk_y = int'(y0);
                end
                mirror_sel = 3'd0;
            end
            else
            begin
                mirror_sel = mirror_sel + 3'd1;
            end
        end
        expected_pixels.push_back(px);
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what,
                                   input logic signed [cor_pkg::PIX_BITS-1:0] got,
                                   input logic signed [cor_pkg::PIX_BITS-1:0] want);
        error_count++;
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // every pixel item taken from the block is held against the oldest
    // prediction still waiting
    always @(posedge clk)
    begin
        if (rst_n && pix_valid && !pix_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                report_mismatch("pixel item with nothing expected, pixel_x",
                                pix.pixel_x, '0);
            end
            else
            begin
                want_pixel = expected_pixels.pop_front();
                if (pix.pixel_x !== want_pixel.pixel_x)
                    report_mismatch("pixel_x", pix.pixel_x, want_pixel.pixel_x);
                if (pix.pixel_y !== want_pixel.pixel_y)
                    report_mismatch("pixel_y", pix.pixel_y, want_pixel.pixel_y);
                if (pix.pixel_valid !== want_pixel.pixel_valid)
                    report_mismatch("pixel_valid", pix.pixel_valid,
                                    want_pixel.pixel_valid);
                if (pix.last_pixel !== want_pixel.last_pixel)
                    report_mismatch("last_pixel", pix.last_pixel,
                                    want_pixel.last_pixel);
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver stall pattern, with a counted hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : rx_stall_pattern
        logic [15:0] mask;
        int          phase;
        mask  = '0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            // fresh pattern each time the phase wraps round the sixteen-bit mask
            if (phase == 0)
            begin
                case (rx_style)
                    0:       mask = '0;
                    1:       mask = 16'($urandom) & 16'($urandom);
                    default: mask = 16'($urandom) | 16'($urandom);
                endcase
            end
            if (hold_cycles > 0)
            begin
                pix_stall <= 1'b1;
                hold_cycles--;
            end
            else
            begin
                pix_stall <= mask[phase];
            end
            phase = (phase + 1) % 16;
        end
    end

    // ------------------------------------------------------------------
    // sending
    // ------------------------------------------------------------------

    // offers one command item and returns at the edge that accepts it;
    // valid stays high into the next item unless a gap is due
    task automatic send_cmd(input cor_pkg::cmd_item_t c);
        if (burst_left == 0)
        begin
            if (gap_max > 0)
            begin
                cmd_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        cmd_valid <= 1'b1;
        cmd       <= c;
        do @(posedge clk); while (cmd_stall);
        predict_pixel(c);
        items_sent++;
    endtask

    task automatic send_start(input int cx, input int cy, input int r);
        cor_pkg::cmd_item_t c;
        c.opcode   = cor_pkg::OP_START;
        c.center_x = cor_pkg::CENTER_W'(cx);
        c.center_y = cor_pkg::CENTER_W'(cy);
        c.radius   = cor_pkg::RADIUS_W'(r);
        send_cmd(c);
    endtask

    // request with random junk in the fields the block ignores
    task automatic send_step();
        cor_pkg::cmd_item_t c;
        c.opcode   = cor_pkg::OP_STEP;
        c.center_x = cor_pkg::CENTER_W'($urandom);
        c.center_y = cor_pkg::CENTER_W'($urandom);
        c.radius   = cor_pkg::RADIUS_W'($urandom);
        send_cmd(c);
    endtask

    task automatic pick_idling();
        case ($urandom_range(0, 3))
            0, 1:    gap_max = 0;
            2:       gap_max = 3;
            default: gap_max = 8;
        endcase
        rx_style = $urandom_range(0, 2);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // request straight after reset, nothing loaded yet
    task automatic test_idle_request();
        send_step();
    endtask

    // starts a large circle and leaves it mid-walk, so the next start drops the old one
    task automatic test_restart_while_busy();
        send_start(1023, 1023, 511);
        repeat (2) send_step();
    endtask

    // radius zero gives eight centre pixels, then one idle request
    task automatic test_zero_radius();
        send_start(0, 0, 0);
        repeat (9) send_step();
    endtask

    // widest radius at the origin so four mirrors go negative
    task automatic test_extreme_centres();
        send_start(0, 0, 511);
        repeat (8) send_step();
    endtask

    // long receiver hold-off while the sender keeps offering requests,
    // so the output register fills and the command side stalls
    task automatic test_receiver_holdoff();
        gap_max     = 0;
        rx_style    = 0;
        send_start(512, 512, 60);
        hold_cycles = 250;
        repeat (60) send_step();
    endtask

    // mostly whole small circles with random centres; some cut short,
    // some large radii abandoned early, and a little raw noise
    task automatic test_random_circles();
        int first_item;
        int kind;
        cor_pkg::cmd_item_t c;
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_ITEMS)
        begin
            pick_idling();
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    c.opcode   = cor_pkg::opcode_t'($urandom_range(0, 1));
                    c.center_x = cor_pkg::CENTER_W'($urandom);
                    c.center_y = cor_pkg::CENTER_W'($urandom);
                    c.radius   = cor_pkg::RADIUS_W'($urandom);
                    send_cmd(c);
                end
            end
            else if (kind == 1)
            begin
                send_start($urandom_range(0, 1023), $urandom_range(0, 1023),
                           $urandom_range(0, 511));
                repeat ($urandom_range(1, 24)) send_step();
            end
            else if (kind == 2)
            begin
                send_start($urandom_range(0, 1023), $urandom_range(0, 1023),
                           $urandom_range(0, 14));
                repeat ($urandom_range(1, 20)) send_step();
            end
            else
            begin
                send_start($urandom_range(0, 1023), $urandom_range(0, 1023),
                           $urandom_range(0, 14));
                while (walk_busy) send_step();
                repeat ($urandom_range(0, 2)) send_step();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin : run_tests
        walk_x     = 0;
        walk_y     = 0;
        mirror_sel = 3'd0;
        held_cx    = '0;
        held_cy    = '0;
        held_r     = '0;
        walk_busy  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_request();
        test_restart_while_busy();
        test_zero_radius();
        test_extreme_centres();
        test_receiver_holdoff();
        test_random_circles();
        cmd_valid <= 1'b0;
        // drain, then keep clocking so that anything unexpected still shows
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // hang guard
    initial
    begin : watchdog
        #TIME_LIMIT;
        $display("Verification failed");
        $finish;
    end

endmodule
